### design/lswc_pkg.sv
// Shared types, widths and constants of the line segment window clipper.
// No dependencies; every other design file imports this package.
package lswc_pkg;

   localparam int COORD_W    = 14;                 // input coordinate width
   localparam int WIN_W      = 12;                 // window register and result width
   localparam int FRAC_W     = 16;                 // fractional bits of t
   localparam int MAG_W      = COORD_W;            // magnitude of p and q
   localparam int DELTA_W    = COORD_W + 1;        // signed endpoint difference
   localparam int NUM_W      = FRAC_W + MAG_W + 1; // dividend incl. rounding half
   localparam int DIV_STAGES = NUM_W;              // one quotient bit per stage
   localparam int RAT_W      = FRAC_W + 3;         // signed, clamped ratio and t
   localparam int PROD_W     = RAT_W + DELTA_W;    // t * delta
   localparam int SUM_W      = PROD_W + 2;         // base*ONE + t*delta + half
   localparam int RES_W      = SUM_W - FRAC_W;     // integer part after rounding
   localparam int NUM_EDGES  = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_W  = 2;

   localparam logic [RAT_W-1:0] T_ONE     = RAT_W'(1) << FRAC_W;
   localparam logic [RAT_W-1:0] RAT_CLAMP = T_ONE + RAT_W'(1);
   localparam logic [WIN_W-1:0] WIN_MAX   = '1;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_X_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_MAX = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_MAX = 2'd3;

   // edge order: left, right, top, bottom
   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_TOP    = 2;
   localparam int EDGE_BOTTOM = 3;

   typedef struct packed {
      logic [WIN_W-1:0] x_min;
      logic [WIN_W-1:0] y_min;
      logic [WIN_W-1:0] x_max;
      logic [WIN_W-1:0] y_max;
   } win_type;

   // one edge test, already classified: p sign and |p|, q sign and |q|
   typedef struct packed {
      logic             p_neg;
      logic             p_zero;
      logic             q_neg;
      logic [MAG_W-1:0] p_mag;
      logic [MAG_W-1:0] q_mag;
   } edge_info_type;

   typedef struct packed {
      edge_info_type [NUM_EDGES-1:0] edges;
      logic signed [COORD_W-1:0]     x0;
      logic signed [COORD_W-1:0]     y0;
      logic signed [DELTA_W-1:0]     dx;
      logic signed [DELTA_W-1:0]     dy;
   } seg_type;

endpackage

### design/line_segment_window_clipper.sv
// Liang-Barsky line segment clipper against a rectangular window.
// Top level; depends on lswc_pkg, lswc_front, lswc_queue and lswc_back.
//
// Usage:
//   req_*  : one segment per word, start and end points as signed coordinates.
//   rsp_*  : one result per segment: clipped endpoints rounded to integers, and
//            a visible flag in rsp_tuser; a rejected segment returns all zeros.
//   csr_*  : window registers, to be written by the user only while the block is
//            idle; the block does not enforce this. Always ready.
// Throughput: one segment per cycle unless the output stalls. Path from the req
//   handshake: front register, queue, a 31-stage restoring divider (one quotient
//   bit per stage, one per window edge, in parallel), a ratio stage, edge-test stages
//   left, right, top, bottom, a multiplier stage and the output register to rsp_tvalid.
// Stall: a held result with rsp_tready low stops the back end; the queue then fills and
//   req_tready drops. A finished result waits in the output register while the
//   pipeline keeps working whenever that register is free or being taken.
// Reset: synchronous, active high; empties the pipeline and queue and sets the
//   window to the full 0..4095 range.
module line_segment_window_clipper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // start_x, start_y, end_x, end_y (14 bits each)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // clip_start_x, clip_start_y, clip_end_x, clip_end_y
   output logic        rsp_tuser,   // visible
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [lswc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lswc_pkg::WIN_W-1:0]     csr_data
);
   import lswc_pkg::*;

   win_type win_ff;
   logic    push_valid, push_ready;
   seg_type push_data;
   logic    pop_valid, pop;
   seg_type pop_data;

   assign csr_ready = 1'b1;

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.x_min <= '0;
         win_ff.y_min <= '0;
         win_ff.x_max <= WIN_MAX;
         win_ff.y_max <= WIN_MAX;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_X_MIN: win_ff.x_min <= csr_data;
            REG_Y_MIN: win_ff.y_min <= csr_data;
            REG_X_MAX: win_ff.x_max <= csr_data;
            REG_Y_MAX: win_ff.y_max <= csr_data;
            default:   win_ff <= win_ff;
         endcase
      end
   end

   // classify the segment against each edge
   lswc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .win        (win_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // decouple front and back so each can stall alone
   lswc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   // divide, test edges, place endpoints
   lswc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pop_valid),
      .in_pop     (pop),
      .in_data    (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### design/lswc_front.sv
// Front end: accepts segments, forms p and q of the edge tests against each window edge.
// Depends on lswc_pkg.
module lswc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,
   input  lswc_pkg::win_type     win,
   output logic                  push_valid,
   output lswc_pkg::seg_type     push_data,
   input  logic                  push_ready
);
   import lswc_pkg::*;

   logic signed [COORD_W-1:0] x0, y0, x1, y1;
   logic signed [DELTA_W-1:0] dx, dy;
   logic signed [DELTA_W-1:0] q_left, q_right, q_top, q_bottom;
   seg_type seg_in;
   seg_type seg_ff;
   logic    vld_ff;

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [DELTA_W-1:0] v);
      logic signed [DELTA_W-1:0] n;
      n = -v;
      return v[DELTA_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

   function automatic edge_info_type classify(input logic signed [DELTA_W-1:0] p,
                                              input logic signed [DELTA_W-1:0] q);
      edge_info_type e;
      e.p_neg  = p[DELTA_W-1];
      e.p_zero = (p == '0);
      e.q_neg  = q[DELTA_W-1];
      e.p_mag  = mag_of(p);
      e.q_mag  = mag_of(q);
      return e;
   endfunction

   always_comb begin
      x0 = req_tdata[13:0];
      y0 = req_tdata[27:14];
      x1 = req_tdata[41:28];
      y1 = req_tdata[55:42];
      dx = DELTA_W'(x1) - DELTA_W'(x0);
      dy = DELTA_W'(y1) - DELTA_W'(y0);
      q_left   = DELTA_W'(x0) - $signed({3'b000, win.x_min});
      q_right  = $signed({3'b000, win.x_max}) - DELTA_W'(x0);
      q_top    = DELTA_W'(y0) - $signed({3'b000, win.y_min});
      q_bottom = $signed({3'b000, win.y_max}) - DELTA_W'(y0);
      seg_in.edges[EDGE_LEFT]   = classify(-dx, q_left);
      seg_in.edges[EDGE_RIGHT]  = classify(dx, q_right);
      seg_in.edges[EDGE_TOP]    = classify(-dy, q_top);
      seg_in.edges[EDGE_BOTTOM] = classify(dy, q_bottom);
      seg_in.x0 = x0;
      seg_in.y0 = y0;
      seg_in.dx = dx;
      seg_in.dy = dy;
   end

   assign req_tready = !vld_ff || push_ready;
   assign push_valid = vld_ff;
   assign push_data  = seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_tready) begin
         vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         seg_ff <= seg_in;
      end
   end

endmodule

### design/lswc_queue.sv
// Short queue between front and back end of the clipper.
// Depends on lswc_pkg.
module lswc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lswc_pkg::seg_type push_data,
   output logic              pop_valid,
   input  logic              pop,
   output lswc_pkg::seg_type pop_data
);
   import lswc_pkg::*;

   seg_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/lswc_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lswc_pkg.
module lswc_divider (
   input  logic                        clock,
   input  logic                        en,
   input  logic [lswc_pkg::NUM_W-1:0]  num,
   input  logic [lswc_pkg::MAG_W-1:0]  den,
   output logic [lswc_pkg::NUM_W-1:0]  quo
);
   import lswc_pkg::*;

   logic [MAG_W-1:0] rem_ff [DIV_STAGES];
   logic [NUM_W-1:0] acc_ff [DIV_STAGES];
   logic [MAG_W-1:0] den_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [MAG_W-1:0] rem_prev, den_prev, rem_in;
      logic [NUM_W-1:0] acc_prev, acc_in;
      logic [MAG_W:0]   trial, diff;
      logic             ge;

      always_comb begin
         if (k == 0) begin
            rem_prev = '0;
            acc_prev = num;
            den_prev = den;
         end else begin
            rem_prev = rem_ff[k-1];
            acc_prev = acc_ff[k-1];
            den_prev = den_ff[k-1];
         end
         trial  = {rem_prev, acc_prev[NUM_W-1]};
         diff   = trial - {1'b0, den_prev};
         ge     = (trial >= {1'b0, den_prev});
         rem_in = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
         acc_in = {acc_prev[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            acc_ff[k] <= acc_in;
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo = acc_ff[DIV_STAGES-1];

endmodule

### design/lswc_back.sv
// Back end: divides, runs the edge tests for each window edge, places and rounds endpoints.
// Depends on lswc_pkg and lswc_divider.
module lswc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_pop,
   input  lswc_pkg::seg_type         in_data,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [47:0]               rsp_tdata,
   output logic                      rsp_tuser
);
   import lswc_pkg::*;

   typedef struct packed {
      logic                                ok;
      logic signed [RAT_W-1:0]             t_in;
      logic signed [RAT_W-1:0]             t_out;
      logic signed [NUM_EDGES-1:0][RAT_W-1:0] rat;
      seg_type                             seg;
   } edge_state_type;

   logic    en;
   logic    div_vld_ff [DIV_STAGES];
   seg_type div_seg_ff [DIV_STAGES];
   logic [NUM_W-1:0] quo [NUM_EDGES];

   edge_state_type rat_ff;
   logic           rat_vld_ff;
   edge_state_type edge_ff [NUM_EDGES];
   logic           edge_vld_ff [NUM_EDGES];

   logic                      mul_vld_ff, mul_ok_ff;
   logic signed [COORD_W-1:0] mul_x0_ff, mul_y0_ff;
   logic signed [PROD_W-1:0]  prod_ff [4];
   logic                      out_vld_ff, out_vis_ff;
   logic [WIN_W-1:0]          out_crd_ff [4];

   // the whole back end advances unless a finished result is still held
   assign en     = !out_vld_ff || rsp_tready;
   assign in_pop = en;

   for (genvar e = 0; e < NUM_EDGES; e++) begin : g_div
      logic [NUM_W-1:0] num;
      assign num = {1'b0, in_data.edges[e].q_mag, FRAC_W'(0)}
                 + NUM_W'(in_data.edges[e].p_mag >> 1);
      lswc_divider u_div (
         .clock (clock),
         .en    (en),
         .num   (num),
         .den   (in_data.edges[e].p_mag),
         .quo   (quo[e])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) div_vld_ff[k] <= 1'b0;
      end else if (en) begin
         div_vld_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STAGES; k++) div_vld_ff[k] <= div_vld_ff[k-1];
      end
      if (en) begin
         div_seg_ff[0] <= in_data;
         for (int k = 1; k < DIV_STAGES; k++) div_seg_ff[k] <= div_seg_ff[k-1];
      end
   end

   // clamp ratio magnitude just past 1.0: comparisons against t in [0, 1] keep their outcome
   function automatic logic signed [RAT_W-1:0] to_ratio(input logic [NUM_W-1:0] mag,
                                                        input logic neg);
      logic [RAT_W-1:0] m;
      m = (mag > NUM_W'(RAT_CLAMP)) ? RAT_CLAMP : mag[RAT_W-1:0];
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic edge_state_type edge_test(input edge_state_type s, input int e);
      edge_state_type  r;
      logic signed [RAT_W-1:0] q;
      r = s;
      q = s.rat[e];
      priority if (s.seg.edges[e].p_zero) begin
         if (s.seg.edges[e].q_neg) r.ok = 1'b0;
      end else if (s.seg.edges[e].p_neg) begin
         if (q > s.t_out)     r.ok = 1'b0;
         else if (q > s.t_in) r.t_in = q;
      end else begin
         if (q < s.t_in)       r.ok = 1'b0;
         else if (q < s.t_out) r.t_out = q;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rat_vld_ff <= 1'b0;
      end else if (en) begin
         rat_vld_ff <= div_vld_ff[DIV_STAGES-1];
      end
      if (en) begin
         rat_ff.ok    <= 1'b1;
         rat_ff.t_in  <= '0;
         rat_ff.t_out <= $signed(T_ONE);
         rat_ff.seg   <= div_seg_ff[DIV_STAGES-1];
         for (int e = 0; e < NUM_EDGES; e++) begin
            rat_ff.rat[e] <= to_ratio(quo[e], div_seg_ff[DIV_STAGES-1].edges[e].p_neg
                                            ^ div_seg_ff[DIV_STAGES-1].edges[e].q_neg);
         end
      end
   end

   // one edge test per stage, in the order left, right, top, bottom
   for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
      edge_state_type prev;
      logic           prev_vld;
      if (e == 0) begin : g_first
         assign prev     = rat_ff;
         assign prev_vld = rat_vld_ff;
      end else begin : g_next
         assign prev     = edge_ff[e-1];
         assign prev_vld = edge_vld_ff[e-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            edge_vld_ff[e] <= 1'b0;
         end else if (en) begin
            edge_vld_ff[e] <= prev_vld;
         end
         if (en) begin
            edge_ff[e] <= edge_test(prev, e);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (en) begin
         mul_vld_ff <= edge_vld_ff[NUM_EDGES-1];
      end
      if (en) begin
         mul_ok_ff  <= edge_ff[NUM_EDGES-1].ok;
         mul_x0_ff  <= edge_ff[NUM_EDGES-1].seg.x0;
         mul_y0_ff  <= edge_ff[NUM_EDGES-1].seg.y0;
         prod_ff[0] <= edge_ff[NUM_EDGES-1].t_in  * edge_ff[NUM_EDGES-1].seg.dx;
         prod_ff[1] <= edge_ff[NUM_EDGES-1].t_in  * edge_ff[NUM_EDGES-1].seg.dy;
         prod_ff[2] <= edge_ff[NUM_EDGES-1].t_out * edge_ff[NUM_EDGES-1].seg.dx;
         prod_ff[3] <= edge_ff[NUM_EDGES-1].t_out * edge_ff[NUM_EDGES-1].seg.dy;
      end
   end

   // base + t*d, rounded half up, saturated to the 12-bit range 0..4095
   function automatic logic [WIN_W-1:0] place(input logic signed [COORD_W-1:0] base,
                                              input logic signed [PROD_W-1:0] prod);
      logic signed [SUM_W-1:0] v;
      logic signed [RES_W-1:0] r;
      v = (SUM_W'(base) <<< FRAC_W) + SUM_W'(prod) + (SUM_W'(1) <<< (FRAC_W - 1));
      r = RES_W'(v >>> FRAC_W);
      if (r < 0)                            return '0;
      else if (r > $signed(RES_W'(WIN_MAX))) return WIN_MAX;
      else                                  return r[WIN_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= mul_vld_ff;
      end
      if (en) begin
         out_vis_ff    <= mul_ok_ff;
         out_crd_ff[0] <= mul_ok_ff ? place(mul_x0_ff, prod_ff[0]) : '0;
         out_crd_ff[1] <= mul_ok_ff ? place(mul_y0_ff, prod_ff[1]) : '0;
         out_crd_ff[2] <= mul_ok_ff ? place(mul_x0_ff, prod_ff[2]) : '0;
         out_crd_ff[3] <= mul_ok_ff ? place(mul_y0_ff, prod_ff[3]) : '0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_vis_ff;
   assign rsp_tdata  = {out_crd_ff[3], out_crd_ff[2], out_crd_ff[1], out_crd_ff[0]};

endmodule

### test/line_segment_window_clipper_tb.sv
// Testbench of the line segment window clipper: drives segments and window
// settings, predicts each clipped result and checks it. Depends on lswc_pkg and line_segment_window_clipper.
module line_segment_window_clipper_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lswc_pkg::*;

   localparam longint FIX_ONE = 64'sd1 << 16;
   localparam int     WATCHDOG_LIMIT = 20000;
   localparam int     DRAIN_CYCLES = 80;

   typedef struct packed {
      logic        visible;
      logic [11:0] sx, sy, ex, ey;
   } clip_result_type;

   // Window copy, expected-result store and mismatch counting.
   class clip_scoreboard;
      logic [11:0]     x_min, y_min, x_max, y_max;
      clip_result_type pending[$];
      int              mismatches;
      int              checked;
      int              visible_seen;

      function void reset_window();
         x_min = '0; y_min = '0; x_max = 12'hFFF; y_max = 12'hFFF;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [11:0] val);
         case (idx)
            REG_X_MIN: x_min = val;
            REG_Y_MIN: y_min = val;
            REG_X_MAX: x_max = val;
            REG_Y_MAX: y_max = val;
            default: ;
         endcase
      endfunction

      // q/p in 16-bit fixed point, halves away from zero
      function longint ratio(longint q, longint p);
         longint num, den, mag;
         num = (q < 0 ? -q : q) <<< 16;
         den = p < 0 ? -p : p;
         mag = (num + den / 2) / den;
         return ((q < 0) != (p < 0)) ? -mag : mag;
      endfunction

      // returns 0 when this edge rejects the segment
      function bit edge_pass(longint p, longint q, inout longint t_in, inout longint t_out);
         longint r;
         if (p < 0) begin
            r = ratio(q, p);
            if (r > t_out) return 0;
            if (r > t_in) t_in = r;
         end else if (p > 0) begin
            r = ratio(q, p);
            if (r < t_in) return 0;
            if (r < t_out) t_out = r;
         end else if (q < 0) begin
            return 0;
         end
         return 1;
      endfunction

      // base + t*d, floor-rounded after adding a half, saturated to 0..4095
      function logic [11:0] place(longint base, longint t, longint d);
         longint v;
         v = base * FIX_ONE + t * d + FIX_ONE / 2;
         v = v >>> 16;
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         return v[11:0];
      endfunction

      function void note_segment(logic [55:0] word);
         longint x0, y0, x1, y1, dx, dy, t_in, t_out;
         bit ok;
         clip_result_type res;
         x0 = longint'($signed(word[13:0]));
         y0 = longint'($signed(word[27:14]));
         x1 = longint'($signed(word[41:28]));
         y1 = longint'($signed(word[55:42]));
         dx = x1 - x0; dy = y1 - y0;
         t_in = 0; t_out = FIX_ONE;
         ok = edge_pass(-dx, x0 - longint'(x_min), t_in, t_out)
            && edge_pass(dx, longint'(x_max) - x0, t_in, t_out)
            && edge_pass(-dy, y0 - longint'(y_min), t_in, t_out)
            && edge_pass(dy, longint'(y_max) - y0, t_in, t_out);
         res = '0;
         if (ok) begin
            res.visible = 1;
            res.sx = place(x0, t_in, dx);
            res.sy = place(y0, t_in, dy);
            res.ex = place(x0, t_out, dx);
            res.ey = place(y0, t_out, dy);
         end
         pending.push_back(res);
      endfunction

      function void check_result(logic [47:0] data, logic vis);
         clip_result_type want, got;
         got = {vis, data[11:0], data[23:12], data[35:24], data[47:36]};
         checked++;
         if (got.visible) visible_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d vis %b/%b start %0d,%0d/%0d,%0d end %0d,%0d/%0d,%0d",
                  checked, want.visible, got.visible, want.sx, want.sy, got.sx, got.sy,
                  want.ex, want.ey, got.ex, got.ey);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WIN_W-1:0]     csr_data = '0;

   clip_scoreboard board = new();
   int  idle_cycles;
   bit  stall_off;     // phases with no idling on either side
   int  segments_sent;

   line_segment_window_clipper dut (.*);

   always #5 clock = ~clock;

   // Watchdog: count cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: random stall per word, check every accepted result.
   initial begin : receiver
      int wait_n;
      @(posedge clock iff !reset);
      forever begin
         wait_n = stall_off ? 0 : $urandom_range(0, 18);
         if (wait_n > 0) begin
            rsp_tready <= 0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock iff rsp_tvalid);
         board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Write one window register; only called while the block is idle.
   task automatic write_window(logic [CSR_IDX_W-1:0] idx, logic [11:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock iff csr_ready);
      board.write_reg(idx, val);
   endtask

   task automatic set_window(logic [11:0] x0, logic [11:0] y0, logic [11:0] x1,
                             logic [11:0] y1);
      write_window(REG_X_MIN, x0);
      write_window(REG_Y_MIN, y0);
      write_window(REG_X_MAX, x1);
      write_window(REG_Y_MAX, y1);
      csr_valid <= 0;
   endtask

   // Send one segment with a random gap in front; valid stays high back to back.
   task automatic send_segment(logic [13:0] x0, logic [13:0] y0, logic [13:0] x1,
                               logic [13:0] y1);
      int gap;
      gap = stall_off ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {y1, x1, y0, x0};
      @(posedge clock iff req_tready);
      board.note_segment({y1, x1, y0, x0});
      segments_sent++;
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [13:0] rand_coord(logic [11:0] lo, logic [11:0] hi);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) return 14'($urandom);               // full field, any bit pattern
      if (sel < 4) return sel == 2 ? 14'h2000 : 14'h1FFF;
      if (sel == 4) return 14'(lo);
      if (sel == 5) return 14'(hi);
      return 14'($urandom_range(int'(lo), int'(hi)) + $urandom_range(0, 40) - 20);
   endfunction

   // Random segments aimed mostly around the current window.
   task automatic random_segments(int count);
      logic [13:0] ax, ay, bx, by;
      for (int i = 0; i < count; i++) begin
         ax = rand_coord(board.x_min, board.x_max);
         ay = rand_coord(board.y_min, board.y_max);
         if ($urandom_range(0, 7) == 0) begin
            bx = ax; by = ay;                          // single point
         end else if ($urandom_range(0, 5) == 0) begin
            bx = ax; by = rand_coord(board.y_min, board.y_max);
         end else begin
            bx = rand_coord(board.x_min, board.x_max);
            by = $urandom_range(0, 5) == 0 ? ay : rand_coord(board.y_min, board.y_max);
         end
         send_segment(ax, ay, bx, by);
      end
   endtask

   initial begin : stimulus
      board.reset_window();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset window, extremes, degenerate and touching segments.
      send_segment(14'h2000, 14'h2000, 14'h1FFF, 14'h1FFF);
      send_segment(14'h1FFF, 14'h2000, 14'h2000, 14'h1FFF);
      send_segment(14'd0, 14'd0, 14'd4095, 14'd4095);
      send_segment(14'd100, 14'd100, 14'd100, 14'd100);
      send_segment(-14'sd5, 14'd10, -14'sd5, 14'd10);
      send_segment(-14'sd10, 14'd0, 14'd0, -14'sd10);     // passes near a corner, outside
      send_segment(-14'sd10, 14'd50, 14'd5000, 14'd50);
      send_segment(14'd50, -14'sd1, 14'd60, -14'sd1);     // parallel, outside
      send_segment(14'd3, 14'h3FFF, 14'h3FFF, 14'h3FFF);
      drain();

      // Small window; touching, inverted, and an ignored index is not reachable.
      set_window(12'd100, 12'd200, 12'd300, 12'd400);
      send_segment(14'd0, 14'd300, 14'd1000, 14'd300);
      send_segment(14'd100, 14'd0, 14'd100, 14'd1000);
      send_segment(14'd0, 14'd99, 14'd200, 14'd301);
      send_segment(14'd300, 14'd400, 14'd301, 14'd401);
      send_segment(14'd301, 14'd401, 14'd301, 14'd401);
      send_segment(14'd0, 14'd0, 14'd7, 14'd3);
      drain();
      set_window(12'd500, 12'd500, 12'd400, 12'd400);   // inverted
      send_segment(14'd0, 14'd0, 14'd1000, 14'd1000);
      send_segment(14'd450, 14'd450, 14'd450, 14'd450);
      drain();

      // Random phases through several windows, extremes among them.
      for (int ph = 0; ph < 9; ph++) begin
         stall_off = (ph == 3 || ph == 7);
         case (ph)
            0: set_window(12'd0, 12'd0, 12'hFFF, 12'hFFF);
            1: set_window(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
            2: set_window(12'd0, 12'd0, 12'd0, 12'd0);
            5: set_window(12'hFFF, 12'd0, 12'd0, 12'hFFF);
            default: begin
               logic [11:0] a, b, c, d;
               a = 12'($urandom); b = 12'($urandom); c = 12'($urandom); d = 12'($urandom);
               if ($urandom_range(0, 3) != 0) begin
                  if (a > c) {a, c} = {c, a};
                  if (b > d) {b, d} = {d, b};
               end
               set_window(a, b, c, d);
            end
         endcase
         random_segments(ph == 1 || ph == 2 ? 50 : 110);
         drain();
         repeat (DRAIN_CYCLES) @(posedge clock);
      end

      $display("tb: %0d segments sent, %0d results checked, %0d visible, over several windows",
               segments_sent, board.checked, board.visible_seen);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

### sim.f
design/lswc_pkg.sv
design/lswc_front.sv
design/lswc_queue.sv
design/lswc_divider.sv
design/lswc_back.sv
design/line_segment_window_clipper.sv
test/line_segment_window_clipper_tb.sv
